[hw/rtl/lsps_pkg.sv]
// Shared types, codes and helper functions for the load switch power sequencer.
// No dependencies; used by lsps_step and the top level.
`timescale 1ns / 1ps

package lsps_pkg;

  // Field and register widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned PulseW  = 16;
  localparam int unsigned CdSecW  = 12;
  localparam int unsigned PauseW  = 16;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // Countdown elapsed time is kept as whole seconds plus milliseconds
  localparam int unsigned ElSecW = 13;
  localparam int unsigned ElMsW  = 10;

  // Saturation point of the 22-bit millisecond counter, split into sec/ms
  localparam logic [ElSecW-1:0] ElSecMax = ElSecW'(4194);
  localparam logic [ElMsW-1:0]  ElMsMax  = ElMsW'(303);
  localparam logic [ElMsW-1:0]  MsLast   = ElMsW'(999);

  // Register reset values
  localparam logic [PulseW-1:0] PulseRst = PulseW'(2000);
  localparam logic [CdSecW-1:0] CdSecRst = CdSecW'(60);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPulse = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegCdSec = CfgIdxW'(1);

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_TICK     = 3'd0,
    CMD_SET_PWR  = 3'd1,
    CMD_HARD_RST = 3'd2,
    CMD_SET_IGN  = 3'd3,
    CMD_PAUSE    = 3'd4
  } cmd_t;

  // Reported mode codes
  localparam logic [ModeW-1:0] ModeCodeOff  = 3'd0;
  localparam logic [ModeW-1:0] ModeCodeAct  = 3'd1;
  localparam logic [ModeW-1:0] ModeCodeRbt  = 3'd2;
  localparam logic [ModeW-1:0] ModeCodeCd   = 3'd3;
  localparam logic [ModeW-1:0] ModeCodeFlt  = 3'd4;

  // Internal mode state, one-hot
  typedef enum logic [4:0] {
    MODE_OFF    = 5'b00001,
    MODE_ACTIVE = 5'b00010,
    MODE_REBOOT = 5'b00100,
    MODE_CD     = 5'b01000,
    MODE_FAULT  = 5'b10000
  } mode_t;

  // Full sequencer state
  typedef struct packed {
    mode_t              mode;
    logic               enable;
    logic               fault;
    logic               ign_on;
    logic [PulseW-1:0]  reb_el;
    logic [ElSecW-1:0]  cd_sec;
    logic [ElMsW-1:0]   cd_ms;
    logic               pause_act;
    logic [PauseW-1:0]  pause_left;
  } seq_state_t;

  // One result item
  typedef struct packed {
    logic               enable;
    logic [ModeW-1:0]   mode;
    logic               fault;
    logic [CdSecW-1:0]  rem_sec;
  } seq_result_t;

  // Apply a power request; power-on is refused while a fault is latched
  function automatic seq_state_t pwr_request(seq_state_t s, logic on);
    seq_state_t r;
    r = s;
    if (!(on && s.fault)) begin
      r.enable = on;
      r.mode   = on ? MODE_ACTIVE : MODE_OFF;
    end
    return r;
  endfunction

  // Map one-hot mode to its reported code
  function automatic logic [ModeW-1:0] mode_code(mode_t m);
    logic [ModeW-1:0] c;
    case (m)
      MODE_OFF:    c = ModeCodeOff;
      MODE_ACTIVE: c = ModeCodeAct;
      MODE_REBOOT: c = ModeCodeRbt;
      MODE_CD:     c = ModeCodeCd;
      MODE_FAULT:  c = ModeCodeFlt;
      default:     c = ModeCodeOff;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/lsps_step.sv]
// Next-state and result logic for one item of the power sequencer.
// Depends on lsps_pkg; purely combinational.
`timescale 1ns / 1ps

module lsps_step
  import lsps_pkg::*;
(
  input  seq_state_t          cur,
  input  logic [CmdW-1:0]     cmd,
  input  logic                flag,
  input  logic [PauseW-1:0]   pause_ms,
  input  logic                fault_n,
  input  logic [PulseW-1:0]   pulse_ms,
  input  logic [CdSecW-1:0]   cd_total_sec,
  output seq_state_t          nxt,
  output seq_result_t         res
);

  seq_state_t        s;
  logic [ElSecW-1:0] diff;
  logic              cd_sat;

  // Apply the command to the state
  always_comb begin
    s      = cur;
    cd_sat = (cur.cd_sec == ElSecMax) && (cur.cd_ms == ElMsMax);
    case (cmd)
      CMD_TICK: begin
        // advance timers, saturating
        if (s.reb_el != '1) s.reb_el = s.reb_el + PulseW'(1);
        if (!cd_sat) begin
          if (s.cd_ms == MsLast) begin
            s.cd_ms  = '0;
            s.cd_sec = s.cd_sec + ElSecW'(1);
          end else begin
            s.cd_ms = s.cd_ms + ElMsW'(1);
          end
        end
        if (s.pause_act && (s.pause_left != '0)) s.pause_left = s.pause_left - PauseW'(1);
        // sample the overcurrent input
        if (!fault_n && !s.fault) begin
          s.fault  = 1'b1;
          s.mode   = MODE_FAULT;
          s.enable = 1'b0;
        end else if (fault_n && s.fault) begin
          s.fault = 1'b0;
        end
        // finish expired reboot, countdown and pause
        if ((s.mode == MODE_REBOOT) && (s.reb_el >= pulse_ms)) s = pwr_request(s, 1'b1);
        if ((s.mode == MODE_CD) && (s.cd_sec >= {1'b0, cd_total_sec}))
          s = pwr_request(s, 1'b0);
        if (s.pause_act && (s.pause_left == '0)) begin
          s.pause_act = 1'b0;
          if (s.ign_on) s = pwr_request(s, 1'b1);
        end
      end
      CMD_SET_PWR: begin
        s = pwr_request(s, flag);
      end
      CMD_HARD_RST: begin
        s.enable = 1'b0;
        s.mode   = MODE_REBOOT;
        s.reb_el = '0;
      end
      CMD_SET_IGN: begin
        if (flag != s.ign_on) begin
          s.ign_on = flag;
          if (!flag) begin
            s.mode   = MODE_CD;
            s.cd_sec = '0;
            s.cd_ms  = '0;
          end else begin
            s.cd_sec = ElSecMax;
            s.cd_ms  = ElMsMax;
            s        = pwr_request(s, 1'b1);
          end
        end
      end
      CMD_PAUSE: begin
        s.enable     = 1'b0;
        s.pause_act  = 1'b1;
        s.pause_left = pause_ms;
      end
      default: begin
        s = cur;
      end
    endcase
    nxt = s;
  end

  // Build the result: whole seconds left, rounded down
  always_comb begin
    diff        = {1'b0, cd_total_sec} - s.cd_sec;
    res.enable  = s.enable;
    res.mode    = mode_code(s.mode);
    res.fault   = s.fault;
    res.rem_sec = '0;
    if ((s.mode == MODE_CD) && (s.cd_sec < {1'b0, cd_total_sec})) begin
      if (s.cd_ms == '0) res.rem_sec = diff[CdSecW-1:0];
      else               res.rem_sec = diff[CdSecW-1:0] - CdSecW'(1);
    end
  end

endmodule

[hw/rtl/usb_load_switch_power_sequencer.sv]
// Top level of the load switch power sequencer: input register, state,
// configuration registers and result register. Depends on lsps_pkg, lsps_step.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------------
//   in_     | into      | in_valid / in_stall   | command, flag, pause_ms, fault_n
//   out_    | out of    | out_valid / out_stall | enable_out, mode, fault_flag, remaining_sec
//   cfg_    | into      | cfg_valid / cfg_ready | cfg_index, cfg_wdata
//
// An accepted item is held in the input register, then passes through the step
// logic into the result register.
// One item is accepted per cycle as long as the result side keeps up.
// in_stall rises only when both the input and result registers hold items and
// out_stall is high. Reset (rst_n low, synchronous) empties both registers and
// returns state to active with the enable on. cfg_ready is always high.
`timescale 1ns / 1ps

module usb_load_switch_power_sequencer
  import lsps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input items
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CmdW-1:0]     in_command,
  input  logic                in_flag,
  input  logic [PauseW-1:0]   in_pause_ms,
  input  logic                in_fault_n,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_enable_out,
  output logic [ModeW-1:0]    out_mode,
  output logic                out_fault_flag,
  output logic [CdSecW-1:0]   out_remaining_sec,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDatW-1:0]  cfg_wdata
);

  localparam seq_state_t StateRst = '{
    mode:       MODE_ACTIVE,
    enable:     1'b1,
    fault:      1'b0,
    ign_on:     1'b1,
    reb_el:     '0,
    cd_sec:     '0,
    cd_ms:      '0,
    pause_act:  1'b0,
    pause_left: '0
  };

  logic                in_valid_r;
  logic [CmdW-1:0]     in_cmd_r;
  logic                in_flag_r;
  logic [PauseW-1:0]   in_pause_r;
  logic                in_fault_n_r;
  logic                out_valid_r;
  seq_result_t         res_r;
  seq_state_t          st_r;
  seq_state_t          st_nxt;
  seq_result_t         res_nxt;
  logic [PulseW-1:0]   pulse_r;
  logic [CdSecW-1:0]   cd_sec_r;
  logic                advance;

  // Move the held item into the result register when that register is free
  assign advance   = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  // Capture incoming items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_cmd_r     <= in_command;
      in_flag_r    <= in_flag;
      in_pause_r   <= in_pause_ms;
      in_fault_n_r <= in_fault_n;
    end
  end

  // Compute next state and result
  lsps_step u_step (
    .cur          (st_r),
    .cmd          (in_cmd_r),
    .flag         (in_flag_r),
    .pause_ms     (in_pause_r),
    .fault_n      (in_fault_n_r),
    .pulse_ms     (pulse_r),
    .cd_total_sec (cd_sec_r),
    .nxt          (st_nxt),
    .res          (res_nxt)
  );

  // Commit state once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StateRst;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Hold or drop the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r  <= PulseRst;
      cd_sec_r <= CdSecRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegPulse: pulse_r  <= cfg_wdata[PulseW-1:0];
        RegCdSec: cd_sec_r <= cfg_wdata[CdSecW-1:0];
        default:  ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_enable_out    = res_r.enable;
  assign out_mode          = res_r.mode;
  assign out_fault_flag    = res_r.fault;
  assign out_remaining_sec = res_r.rem_sec;

`ifndef SYNTHESIS
  // A latched fault always keeps the switch off
  a_fault_off: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fault |-> !st_r.enable)
    else $error("enable high while fault latched");

  // Off, reboot and fault modes never drive the enable
  a_mode_off: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == MODE_OFF || st_r.mode == MODE_REBOOT || st_r.mode == MODE_FAULT)
    |-> !st_r.enable)
    else $error("enable high in a powered-down mode");

  // Millisecond part of the countdown stays below one second
  a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cd_ms <= MsLast)
    else $error("countdown millisecond field out of range");

  // Seconds left are reported only in countdown mode
  a_rem_cd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_remaining_sec != '0) |-> (out_mode == ModeCodeCd))
    else $error("remaining seconds outside countdown");
`endif

endmodule
